>>> rtl/mime_boundary_signature_matcher_macros.svh
// Assertion macros shared by the boundary signature matcher.
`ifndef MIME_BOUNDARY_SIGNATURE_MATCHER_MACROS_SVH
`define MIME_BOUNDARY_SIGNATURE_MATCHER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MBSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MBSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbsm_pkg.sv
// Types and constants shared by the boundary signature matcher modules.
package mbsm_pkg;

  localparam int BYTE_W    = 8;
  localparam int VERDICT_W = 2;

  // Result codes.
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_MARK   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd2;

  // Keyword "boundary".
  localparam int KW_LEN   = 8;
  localparam int KW_IDX_W = $clog2(KW_LEN);
  localparam logic [BYTE_W-1:0] KEYWORD [KW_LEN] = '{
    8'h62, 8'h6F, 8'h75, 8'h6E, 8'h64, 8'h61, 8'h72, 8'h79
  };

  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_USCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

  // Signature layout: "----=" then letters, then the digit run starting at
  // one of four offsets.
  localparam int SIG_DASHES   = 4;
  localparam int SIG_PREFIX   = 5;
  localparam int SIG_MIN_OFF  = 8;
  localparam int SIG_NUM_OFF  = 4;
  localparam int SIG_MIN_LEN  = 32;
  localparam int SIG_MAX_LEN  = 36;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified header byte.
  typedef struct packed {
    logic              is_nul;
    logic              is_quote;
    logic              is_dash;
    logic              is_eq;
    logic              is_digit;
    logic              is_alpha;
    logic              is_uscore;
    logic              is_dot;
    logic [KW_LEN-1:0] kw_hit;
    logic              last;
    logic              relay;
    logic              tag_flag;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic pop_last;
  } back_stat_t;

endpackage

>>> rtl/mbsm_front.sv
// Front end: takes header bytes, holds the case register and classifies each byte.
module mbsm_front import mbsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic              in_relay,
  input  logic              in_tagged,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  q_stat_t           q_stat,
  output logic              push,
  output item_t             push_item
);

  logic              icase_r;
  logic              icase_nxt;
  logic [BYTE_W-1:0] folded;

  assign cfg_ready = 1'b1;
  assign icase_nxt = (cfg_valid && cfg_ready) ? cfg_data : icase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icase_r <= 1'b1;
    end else begin
      icase_r <= icase_nxt;
    end
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    folded = in_byte;
    if (icase_r && in_byte >= CH_UPPER_A && in_byte <= CH_UPPER_Z) begin
      folded = in_byte + CASE_DELTA;
    end
  end

  always_comb begin
    push_item.is_nul    = (in_byte == '0);
    push_item.is_quote  = (in_byte == CH_QUOTE);
    push_item.is_dash   = (in_byte == CH_DASH);
    push_item.is_eq     = (in_byte == CH_EQ);
    push_item.is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    push_item.is_alpha  = ((in_byte >= CH_LOWER_A) && (in_byte <= CH_LOWER_Z)) ||
                          ((in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z));
    push_item.is_uscore = (in_byte == CH_USCORE);
    push_item.is_dot    = (in_byte == CH_DOT);
    for (int k = 0; k < KW_LEN; k++) begin
      push_item.kw_hit[k] = (folded == KEYWORD[k]);
    end
    push_item.last     = in_last;
    push_item.relay    = in_relay;
    push_item.tag_flag = in_tagged;
  end

endmodule

>>> rtl/mbsm_queue.sv
// Short queue of classified items between the front and the back end.
module mbsm_queue import mbsm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t q_stat
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.count = count_r;

endmodule

>>> rtl/mbsm_back.sv
// Back end: scan state, running signature check and the verdict register.
module mbsm_back import mbsm_pkg::*; #(
  parameter int MAX_HEADER_BYTES = 1024,
  parameter int CAPTURE_DEPTH    = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  item_t                head,
  input  q_stat_t              q_stat,
  input  logic                 out_ready,
  output back_stat_t           stat,
  output logic                 out_valid,
  output logic [VERDICT_W-1:0] out_verdict
);

  localparam int BSEEN_W = $clog2(MAX_HEADER_BYTES + 1);
  localparam int CLEN_W  = $clog2(CAPTURE_DEPTH + 2);

  typedef enum logic [3:0] {
    PH_KEYWORD = 4'b0001,
    PH_OPENQ   = 4'b0010,
    PH_CAPTURE = 4'b0100,
    PH_CLOSED  = 4'b1000
  } phase_t;

  phase_t                 phase_r,   phase_nxt;
  logic [KW_IDX_W-1:0]    kw_prog_r, kw_prog_nxt;
  logic [BSEEN_W-1:0]     bytes_r,   bytes_nxt;
  logic                   halted_r,  halted_nxt;
  logic [CLEN_W-1:0]      clen_r,    clen_nxt;
  logic [SIG_NUM_OFF-1:0] ok_r,      ok_nxt;
  logic [SIG_NUM_OFF-1:0] dot17_r,   dot17_nxt;
  logic [SIG_NUM_OFF-1:0] dot18_r,   dot18_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0]   verdict_r, verdict_nxt;
  logic                   can_take;
  logic                   pop;
  logic                   len_ok;
  logic                   sig_match;

  // Does a character at position p fit the signature whose digit run starts at o?
  // Positions that the signature does not constrain always fit.
  function automatic logic char_ok(input int o, input int p, input item_t c);
    logic r;
    r = 1'b1;
    priority if (p < SIG_DASHES)  r = c.is_dash;
    else if (p < SIG_PREFIX)      r = c.is_eq;
    else if (p < o)               r = c.is_alpha;
    else if (p < o + 3)           r = c.is_digit;
    else if (p == o + 3)          r = c.is_uscore;
    else if (p < o + 8)           r = c.is_digit;
    else if (p == o + 8)          r = c.is_uscore;
    else if (p < o + 17)          r = c.is_digit;
    else if (p < o + 19)          r = 1'b1;
    else if (p < o + 24)          r = c.is_digit;
    else                          r = 1'b1;
    return r;
  endfunction

  assign can_take = !out_valid_r || out_ready;
  assign pop      = q_stat.valid && (!head.last || can_take);

  assign stat.pop      = pop;
  assign stat.pop_last = head.last;

  always_comb begin
    phase_nxt   = phase_r;
    kw_prog_nxt = kw_prog_r;
    bytes_nxt   = bytes_r;
    halted_nxt  = halted_r;
    clen_nxt    = clen_r;
    ok_nxt      = ok_r;
    dot17_nxt   = dot17_r;
    dot18_nxt   = dot18_r;
    if (!halted_r && bytes_r < BSEEN_W'(MAX_HEADER_BYTES)) begin
      bytes_nxt = bytes_r + 1'b1;
      if (head.is_nul) begin
        halted_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_KEYWORD: begin
            if (head.kw_hit[kw_prog_r]) begin
              if (kw_prog_r == KW_IDX_W'(KW_LEN - 1)) begin
                kw_prog_nxt = '0;
                phase_nxt   = PH_OPENQ;
              end else begin
                kw_prog_nxt = kw_prog_r + 1'b1;
              end
            end else begin
              // A mismatch may still start a new keyword.
              kw_prog_nxt = KW_IDX_W'(head.kw_hit[0]);
            end
          end
          PH_OPENQ: begin
            if (head.is_quote) begin
              phase_nxt = PH_CAPTURE;
              clen_nxt  = '0;
            end
          end
          PH_CAPTURE: begin
            if (head.is_quote) begin
              phase_nxt = PH_CLOSED;
            end else begin
              for (int k = 0; k < SIG_NUM_OFF; k++) begin
                ok_nxt[k] = ok_r[k] & char_ok(SIG_MIN_OFF + k, int'(clen_r), head);
                if (head.is_dot && int'(clen_r) == SIG_MIN_OFF + k + 17) begin
                  dot17_nxt[k] = 1'b1;
                end
                if (head.is_dot && int'(clen_r) == SIG_MIN_OFF + k + 18) begin
                  dot18_nxt[k] = 1'b1;
                end
              end
              if (clen_r <= CLEN_W'(CAPTURE_DEPTH)) begin
                clen_nxt = clen_r + 1'b1;
              end
            end
          end
          PH_CLOSED: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    len_ok    = (clen_nxt >= CLEN_W'(SIG_MIN_LEN)) && (clen_nxt <= CLEN_W'(SIG_MAX_LEN));
    sig_match = 1'b0;
    for (int k = 0; k < SIG_NUM_OFF; k++) begin
      // Every checked position must lie inside the capture.
      if (ok_nxt[k] && int'(clen_nxt) > SIG_MIN_OFF + k + 23 &&
          (dot17_nxt[k] || dot18_nxt[k])) begin
        sig_match = 1'b1;
      end
    end
    verdict_nxt = VERDICT_ACCEPT;
    if (!head.relay && phase_nxt == PH_CLOSED && len_ok && sig_match) begin
      verdict_nxt = head.tag_flag ? VERDICT_MARK : VERDICT_REJECT;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && head.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEYWORD;
      kw_prog_r   <= '0;
      bytes_r     <= '0;
      halted_r    <= 1'b0;
      clen_r      <= '0;
      ok_r        <= '1;
      dot17_r     <= '0;
      dot18_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (head.last) begin
          phase_r   <= PH_KEYWORD;
          kw_prog_r <= '0;
          bytes_r   <= '0;
          halted_r  <= 1'b0;
          clen_r    <= '0;
          ok_r      <= '1;
          dot17_r   <= '0;
          dot18_r   <= '0;
        end else begin
          phase_r   <= phase_nxt;
          kw_prog_r <= kw_prog_nxt;
          bytes_r   <= bytes_nxt;
          halted_r  <= halted_nxt;
          clen_r    <= clen_nxt;
          ok_r      <= ok_nxt;
          dot17_r   <= dot17_nxt;
          dot18_r   <= dot18_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

>>> rtl/mime_boundary_signature_matcher.sv
// Boundary signature matcher for Content-Type headers.
//
// Header bytes enter on the in_ stream, one item per byte, with tlast on
// the final byte of a header. The relay and tagging flags ride in tuser and
// are used only on that final byte. Each header yields one verdict item on
// the out_ stream: accept, accept and mark, or reject.
// The cfg_ channel writes the keyword case-insensitivity bit and is always
// ready; the user must write it only between headers, which the block does not enforce.
// Flow: the last byte is written into the queue; once every item ahead of it
// has been popped, the back end pops it and loads the verdict and its valid
// flag into the output register. Throughput: one byte per cycle while the
// queue is not full; a four-entry queue separates the byte intake from the
// scanner, and the back end holds a last byte in the queue while a verdict
// still waits for the receiver.
// Reset clears all scan state, sets case-insensitive keyword matching and
// empties the queue. When the receiver stalls, the verdict holds; the back
// end keeps consuming bytes until it reaches the next header's last byte,
// and the intake keeps going until the queue is full.
module mime_boundary_signature_matcher import mbsm_pkg::*; #(
  parameter int MAX_HEADER_BYTES = 1024,
  parameter int CAPTURE_DEPTH    = 36
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] header_byte
  input  logic       in_tlast,
  input  logic [1:0] in_tuser,   // [0] relay_mail, [1] sender_tagged
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] verdict, [7:2] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

`include "mime_boundary_signature_matcher_macros.svh"

  q_stat_t              q_stat;
  back_stat_t           back_stat;
  logic                 push;
  item_t                push_item;
  item_t                head;
  logic [VERDICT_W-1:0] verdict;

  mbsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .in_relay  (in_tuser[0]),
    .in_tagged (in_tuser[1]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  mbsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (back_stat.pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  mbsm_back #(
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
    .CAPTURE_DEPTH    (CAPTURE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_stat      (q_stat),
    .out_ready   (out_tready),
    .stat        (back_stat),
    .out_valid   (out_tvalid),
    .out_verdict (verdict)
  );

  assign out_tdata = {{(8 - VERDICT_W){1'b0}}, verdict};

  `MBSM_ASSERT_IMP(a_pop_has_data, back_stat.pop, q_stat.valid, "pop from empty queue")
  `MBSM_ASSERT_IMP(a_count_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue overrun")
  `MBSM_ASSERT_IMP(a_no_verdict_loss, back_stat.pop && back_stat.pop_last, !out_tvalid || out_tready, "pending verdict overwritten")
  `MBSM_ASSERT_IMP(a_verdict_source, $rose(out_tvalid), $past(back_stat.pop && back_stat.pop_last), "verdict without a last item")

endmodule

>>> verif/tb.sv
// Self-checking stream testbench for the boundary signature matcher.
`timescale 1ns / 100ps

module tb;
  import mbsm_pkg::*;

  localparam int HDR_MAX     = 1024;
  localparam int CAP_DEPTH   = 36;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_BYTES  = 1750;
  localparam int DRAIN_WAIT  = 8;
  // The long header takes about HDR_MAX of the byte budget.
  localparam int PHASE_BYTES = (RAND_BYTES - HDR_MAX) / 4;

  typedef enum logic [1:0] {
    SEEK_KEYWORD,
    SEEK_OPEN_QUOTE,
    CAPTURING,
    CLOSED
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] hbyte;
    logic       last;
    logic       relay;
    logic       tag_flag;
    logic       pause;
  } hdr_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;     // [7:0] header_byte
  logic       in_tlast = 1'b0;
  logic [1:0] in_tuser = '0;     // [0] relay_mail, [1] sender_tagged
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [1:0] verdict, [7:2] zero
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  hdr_item_t            pending_bytes[$];
  logic [7:0]           hdr_bytes[$];
  logic [VERDICT_W-1:0] expected_verdicts[$];

  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   errors = 0;
  int   quiet_cycles = 0;
  logic in_took = 1'b0;

  // Predictor state.
  logic        nocase = 1'b1;
  scan_phase_t phase = SEEK_KEYWORD;
  int          kw_pos = 0;
  int          nbytes = 0;
  logic [7:0]  cap [CAP_DEPTH];
  int          cap_len = 0;
  logic        halted = 1'b0;

  mime_boundary_signature_matcher #(
    .MAX_HEADER_BYTES(HDR_MAX),
    .CAPTURE_DEPTH   (CAP_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  // Positions at or past the end of the capture read as zero, which matches nothing.
  function automatic logic [7:0] cap_at(input int p);
    if (p >= cap_len || p >= CAP_DEPTH) return 8'h00;
    return cap[p];
  endfunction

  function automatic bit digit_run(input int from, input int to);
    for (int p = from; p < to; p++)
      if (!is_digit(cap_at(p))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit signature_ok();
    int i;
    int off;
    if (cap_len < SIG_MIN_LEN || cap_len > SIG_MAX_LEN) return 1'b0;
    for (i = 0; i < SIG_DASHES; i++)
      if (cap_at(i) != CH_DASH) return 1'b0;
    if (cap_at(SIG_DASHES) != CH_EQ) return 1'b0;
    i = SIG_PREFIX;
    while (i < SIG_MIN_OFF + SIG_NUM_OFF && is_alpha(cap_at(i))) i++;
    if (i < SIG_MIN_OFF || i >= SIG_MIN_OFF + SIG_NUM_OFF || !is_digit(cap_at(i)))
      return 1'b0;
    off = i;
    if (cap_at(off + 3) != CH_USCORE || cap_at(off + 8) != CH_USCORE) return 1'b0;
    // Either dot position will do; the other one is not looked at.
    if (cap_at(off + 17) != CH_DOT && cap_at(off + 18) != CH_DOT) return 1'b0;
    return digit_run(off, off + 3) && digit_run(off + 4, off + 8) &&
           digit_run(off + 9, off + 17) && digit_run(off + 19, off + 24);
  endfunction

  task automatic scan_byte(input logic [7:0] b);
    logic [7:0] c;
    case (phase)
      SEEK_KEYWORD: begin
        c = b;
        if (nocase && c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_DELTA;
        if (kw_pos < KW_LEN && c == KEYWORD[kw_pos]) kw_pos++;
        else kw_pos = (c == KEYWORD[0]) ? 1 : 0;
        if (kw_pos >= KW_LEN) begin
          kw_pos = 0;
          phase = SEEK_OPEN_QUOTE;
        end
      end
      SEEK_OPEN_QUOTE: begin
        if (b == CH_QUOTE) begin
          phase = CAPTURING;
          cap_len = 0;
        end
      end
      CAPTURING: begin
        if (b == CH_QUOTE) begin
          phase = CLOSED;
        end else begin
          if (cap_len < CAP_DEPTH) cap[cap_len] = b;
          // The length saturates one above the store depth.
          if (cap_len <= CAP_DEPTH) cap_len++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last, relay, tag_flag);
    logic [VERDICT_W-1:0] v;
    if (!halted && nbytes < HDR_MAX) begin
      nbytes++;
      if (b == 8'h00) halted = 1'b1;
      else scan_byte(b);
    end
    if (last) begin
      v = VERDICT_ACCEPT;
      if (!relay && phase == CLOSED && signature_ok())
        v = tag_flag ? VERDICT_MARK : VERDICT_REJECT;
      expected_verdicts.push_back(v);
      phase = SEEK_KEYWORD;
      kw_pos = 0;
      nbytes = 0;
      cap_len = 0;
      halted = 1'b0;
    end
  endtask

  // Input driver: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin : drive_in
    hdr_item_t nxt;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pending_bytes.size() > 0 &&
          !(pending_bytes[0].pause && expected_verdicts.size() > 0) &&
          $urandom_range(99) >= snd_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_tdata  <= nxt.hbyte;
        in_tlast  <= nxt.last;
        in_tuser  <= {nxt.tag_flag, nxt.relay};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    logic [VERDICT_W-1:0] want;
    if (rst_n) begin
      in_took <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) nocase = cfg_data;
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast, in_tuser[0], in_tuser[1]);
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict %0d arrived with none expected", $time,
                   out_tdata[VERDICT_W-1:0]);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_tdata[VERDICT_W-1:0] !== want) begin
            $display("%0t: verdict expected %0d, actual %0d", $time, want,
                     out_tdata[VERDICT_W-1:0]);
            errors++;
          end
          if (out_tdata[7:VERDICT_W] !== '0) begin
            $display("%0t: tdata padding expected 0, actual %0h", $time,
                     out_tdata[7:VERDICT_W]);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    c = CH_QUOTE;
    while (c == CH_QUOTE) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_bytes.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) hdr_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Mostly all lower case, otherwise a random mix of capitals.
  task automatic add_keyword();
    bit mixed;
    mixed = ($urandom_range(9) < 3);
    for (int i = 0; i < KW_LEN; i++)
      hdr_bytes.push_back((mixed && $urandom_range(1)) ? KEYWORD[i] - CASE_DELTA : KEYWORD[i]);
  endtask

  // A well-formed signature when sane; else the letter run and the tail each
  // take zero to eight bytes, so length and offset tests fail now and then.
  task automatic add_signature(input bit sane);
    int nalpha;
    int start;
    start = hdr_bytes.size();
    nalpha = sane ? $urandom_range(3, 6) : $urandom_range(0, 8);
    repeat (SIG_DASHES) hdr_bytes.push_back(CH_DASH);
    hdr_bytes.push_back(CH_EQ);
    repeat (nalpha) hdr_bytes.push_back(rand_letter());
    add_digits(3);
    hdr_bytes.push_back(CH_USCORE);
    add_digits(4);
    hdr_bytes.push_back(CH_USCORE);
    add_digits(8);
    if ($urandom_range(1)) begin
      hdr_bytes.push_back(CH_DOT);
      hdr_bytes.push_back(rand_plain());
    end else begin
      hdr_bytes.push_back(rand_plain());
      hdr_bytes.push_back(CH_DOT);
    end
    add_digits(5);
    if (sane)
      repeat ($urandom_range(0, SIG_MAX_LEN - (hdr_bytes.size() - start)))
        hdr_bytes.push_back(rand_plain());
    else
      repeat ($urandom_range(0, 8)) hdr_bytes.push_back(rand_plain());
  endtask

  task automatic build_header();
    int  kind;
    int  sig_at;
    int  k;
    bit  no_open;
    bit  no_close;
    kind = $urandom_range(0, 9);
    no_open = (kind == 9) && $urandom_range(1);
    no_close = (kind == 9) && !no_open;
    repeat ($urandom_range(0, 6)) hdr_bytes.push_back(rand_plain());
    case (kind)
      5: repeat ($urandom_range(1, 16)) hdr_bytes.push_back(8'($urandom_range(0, 255)));
      6: begin
        add_keyword();
        hdr_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 44)) hdr_bytes.push_back(rand_plain());
        hdr_bytes.push_back(CH_QUOTE);
      end
      default: begin
        // For kind 7, either a capitalized keyword, which only counts when case is
        // ignored, or false starts that force the search to restart; else a keyword.
        if (kind == 7 && $urandom_range(1)) begin
          add_text("BOUNDARY");
        end else begin
          if (kind == 7) add_text("bboundbounda");
          add_keyword();
        end
        repeat ($urandom_range(0, 2)) hdr_bytes.push_back(rand_plain());
        if (!no_open) hdr_bytes.push_back(CH_QUOTE);
        sig_at = hdr_bytes.size();
        add_signature($urandom_range(3) != 0);
        if (kind < 5 && $urandom_range(2) == 0) begin
          k = $urandom_range(sig_at, hdr_bytes.size() - 1);
          if ($urandom_range(1)) hdr_bytes[k] = 8'($urandom_range(0, 255));
          else while (hdr_bytes.size() > k) void'(hdr_bytes.pop_back());
        end
        if (!no_close) hdr_bytes.push_back(CH_QUOTE);
        if (kind == 8) hdr_bytes[$urandom_range(0, hdr_bytes.size() - 1)] = 8'h00;
      end
    endcase
    repeat ($urandom_range(0, 4)) hdr_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Moves the built header into the pending items. A negative flags value
  // draws relay and tagging at random; else bit 0 is relay, bit 1 tagged.
  task automatic emit(input int flags);
    logic r;
    logic t;
    logic p;
    p = ($urandom_range(7) == 0);
    foreach (hdr_bytes[i]) begin
      r = ($urandom_range(3) == 0);
      t = $urandom_range(1);
      if (i == hdr_bytes.size() - 1 && flags >= 0) begin
        r = flags[0];
        t = flags[1];
      end
      pending_bytes.push_back('{hbyte: hdr_bytes[i], last: (i == hdr_bytes.size() - 1),
                                relay: r, tag_flag: t, pause: p && (i == 0)});
    end
    hdr_bytes.delete();
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input logic nocase_val,
                           input bit with_long);
    int         sent;
    logic [7:0] c;
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_cfg(nocase_val);
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    if (with_long) begin
      // Filler with no keyword start, so the signature sits near the byte cap
      // and may be cut off anywhere past its first 14 bytes or fit entirely.
      repeat ($urandom_range(940, 1000)) begin
        c = rand_plain();
        if (c == KEYWORD[0] || c == KEYWORD[0] - CASE_DELTA) c = CH_DOT;
        hdr_bytes.push_back(c);
      end
      add_text("boundary=\"");
      add_signature(1'b1);
      hdr_bytes.push_back(CH_QUOTE);
      emit(-1);
    end
    sent = 0;
    while (sent < PHASE_BYTES) begin
      build_header();
      sent += hdr_bytes.size();
      emit(-1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Short directed headers under the reset setting: NUL and all-ones
    // bytes, an empty capture behind a mixed-case keyword, a lone quote,
    // a NUL that hides a later quote, and the byte extremes around 0x80.
    hdr_bytes.push_back(8'h00);
    emit(3);
    hdr_bytes.push_back(8'hFF);
    emit(0);
    add_text("BoUNDARY=\"\"");
    emit(2);
    hdr_bytes.push_back(CH_QUOTE);
    emit(1);
    hdr_bytes.push_back(KEYWORD[0]);
    hdr_bytes.push_back(8'h00);
    hdr_bytes.push_back(CH_QUOTE);
    emit(0);
    hdr_bytes.push_back(8'h80);
    hdr_bytes.push_back(8'h7F);
    hdr_bytes.push_back(8'h01);
    emit(2);

    run_phase(0, 0, 1'b0, 1'b0);
    run_phase(52, 0, 1'b1, 1'b0);
    run_phase(0, 52, 1'b0, 1'b1);
    run_phase(8, 8, 1'b1, 1'b0);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mbsm_pkg.sv
rtl/mbsm_front.sv
rtl/mbsm_queue.sv
rtl/mbsm_back.sv
rtl/mime_boundary_signature_matcher.sv
verif/tb.sv
